// ===== rtl/core/urm_pkg.sv =====
// Package with the shared types and constants of the 16550 UART register model.
`default_nettype none

package urm_pkg;

    // Item actions.
    typedef logic [1:0] action_t;
    localparam action_t ACT_READ   = 2'd0;
    localparam action_t ACT_WRITE  = 2'd1;
    localparam action_t ACT_RECV   = 2'd2;
    localparam action_t ACT_HANGUP = 2'd3;

    // Register offsets within the 8-entry map.
    typedef logic [2:0] offset_t;
    localparam offset_t OFS_RBR_THR = 3'd0;
    localparam offset_t OFS_IER     = 3'd1;
    localparam offset_t OFS_IIR_FCR = 3'd2;
    localparam offset_t OFS_LCR     = 3'd3;
    localparam offset_t OFS_MCR     = 3'd4;
    localparam offset_t OFS_LSR     = 3'd5;
    localparam offset_t OFS_MSR     = 3'd6;
    localparam offset_t OFS_SCR     = 3'd7;

    // Bit positions and fixed register values.
    localparam int unsigned LCR_DLAB_BIT = 7;
    localparam logic [7:0] LSR_FIXED     = 8'h60;
    localparam logic [7:0] MSR_DCD       = 8'h80;
    localparam logic [7:0] IIR_RX_DATA   = 8'h04;
    localparam logic [7:0] IIR_THR_EMPTY = 8'h02;
    localparam logic [7:0] IIR_NONE      = 8'h01;

    // One captured request.
    typedef struct packed {
        action_t    action;
        offset_t    reg_offset;
        logic [7:0] data_byte;
        logic       hangup;
    } request_t;

endpackage

`default_nettype wire

// ===== rtl/core/uart_16550_register_model_core.sv =====
// Top level of the 16550 UART register model: request register, register file, result register.
`default_nettype none

// A request is taken at any clock edge where start is high; busy never rises, so one
// request per cycle is sustained. Each request yields exactly one result, shown with
// done high for one cycle that begins at the first clock edge after the request was
// taken: the edge that takes the request loads the request register, and the next one
// updates the register file and loads the result register. The receiver cannot stall,
// so results must be taken as they appear. A read of RBR with DLAB clear empties the
// one-byte receive holder; a byte that arrives while the holder is full overwrites it
// silently.
module uart_16550_register_model_core (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    output logic              busy,
    input  wire               [1:0] action,
    input  wire               [2:0] reg_offset,
    input  wire               [7:0] data_byte,
    input  wire               hangup,
    output logic              done,
    output logic [7:0]        read_data,
    output logic              tx_valid,
    output logic [7:0]        tx_byte,
    output logic              interrupt
);
    import urm_pkg::*;

    // Request register.
    logic     req_valid_reg;
    request_t req_reg;

    // Register file.
    logic [7:0] lcr_reg, lcr_next;
    logic [7:0] ier_reg, ier_next;
    logic [7:0] fcr_reg, fcr_next;
    logic [7:0] mcr_reg, mcr_next;
    logic [7:0] scr_reg, scr_next;
    logic [7:0] dll_reg, dll_next;
    logic [7:0] dlm_reg, dlm_next;
    logic [7:0] rx_hold_reg, rx_hold_next;
    logic       rx_full_reg, rx_full_next;
    logic       hung_up_reg, hung_up_next;

    // Result register.
    logic       done_reg;
    logic [7:0] read_data_reg, read_data_next;
    logic       tx_valid_reg, tx_valid_next;
    logic [7:0] tx_byte_reg, tx_byte_next;
    logic       irq_reg, irq_next;

    logic dlab;

    assign busy = 1'b0;

    // Capture each request as it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg <= '{action: action, reg_offset: reg_offset,
                         data_byte: data_byte, hangup: hangup};
        end
    end

    assign dlab = lcr_reg[LCR_DLAB_BIT];

    // Decode the request against the register file.
    always_comb
    begin
        lcr_next       = lcr_reg;
        ier_next       = ier_reg;
        fcr_next       = fcr_reg;
        mcr_next       = mcr_reg;
        scr_next       = scr_reg;
        dll_next       = dll_reg;
        dlm_next       = dlm_reg;
        rx_hold_next   = rx_hold_reg;
        rx_full_next   = rx_full_reg;
        hung_up_next   = hung_up_reg;
        read_data_next = 8'h00;
        tx_valid_next  = 1'b0;
        tx_byte_next   = 8'h00;

        case (req_reg.action)
            ACT_READ:
            begin
                case (req_reg.reg_offset)
                    OFS_RBR_THR:
                    begin
                        if (dlab)
                        begin
                            read_data_next = dll_reg;
                        end
                        else
                        begin
                            read_data_next = rx_hold_reg;
                            rx_full_next   = 1'b0;
                        end
                    end
                    OFS_IER:     read_data_next = dlab ? dlm_reg : ier_reg;
                    OFS_IIR_FCR:
                    begin
                        if (rx_full_reg && ier_reg[0])
                        begin
                            read_data_next = IIR_RX_DATA;
                        end
                        else if (ier_reg[1])
                        begin
                            read_data_next = IIR_THR_EMPTY;
                        end
                        else
                        begin
                            read_data_next = IIR_NONE;
                        end
                    end
                    OFS_LCR:     read_data_next = lcr_reg;
                    OFS_MCR:     read_data_next = mcr_reg;
                    OFS_LSR:     read_data_next = LSR_FIXED | {7'd0, rx_full_reg};
                    OFS_MSR:     read_data_next = hung_up_reg ? 8'h00 : MSR_DCD;
                    default:     read_data_next = scr_reg;
                endcase
            end
            ACT_WRITE:
            begin
                case (req_reg.reg_offset)
                    OFS_RBR_THR:
                    begin
                        if (dlab)
                        begin
                            dll_next = req_reg.data_byte;
                        end
                        else
                        begin
                            tx_valid_next = 1'b1;
                            tx_byte_next  = req_reg.data_byte;
                        end
                    end
                    OFS_IER:
                    begin
                        if (dlab)
                        begin
                            dlm_next = req_reg.data_byte;
                        end
                        else
                        begin
                            ier_next = req_reg.data_byte;
                        end
                    end
                    OFS_IIR_FCR: fcr_next = req_reg.data_byte;
                    OFS_LCR:     lcr_next = req_reg.data_byte;
                    OFS_MCR:     mcr_next = req_reg.data_byte;
                    OFS_SCR:     scr_next = req_reg.data_byte;
                    default:     ;
                endcase
            end
            ACT_RECV:
            begin
                rx_hold_next = req_reg.data_byte;
                rx_full_next = 1'b1;
            end
            default:
            begin
                hung_up_next = req_reg.hangup;
            end
        endcase

        // Interrupt level follows the updated enables and receive state.
        irq_next = ier_next[1] | (ier_next[0] & rx_full_next);
    end

    // Register file update, once per request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcr_reg     <= 8'h00;
            ier_reg     <= 8'h00;
            fcr_reg     <= 8'h00;
            mcr_reg     <= 8'h00;
            scr_reg     <= 8'h00;
            dll_reg     <= 8'h00;
            dlm_reg     <= 8'h00;
            rx_hold_reg <= 8'h00;
            rx_full_reg <= 1'b0;
            hung_up_reg <= 1'b0;
        end
        else if (req_valid_reg)
        begin
            lcr_reg     <= lcr_next;
            ier_reg     <= ier_next;
            fcr_reg     <= fcr_next;
            mcr_reg     <= mcr_next;
            scr_reg     <= scr_next;
            dll_reg     <= dll_next;
            dlm_reg     <= dlm_next;
            rx_hold_reg <= rx_hold_next;
            rx_full_reg <= rx_full_next;
            hung_up_reg <= hung_up_next;
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= req_valid_reg;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (req_valid_reg)
        begin
            read_data_reg <= read_data_next;
            tx_valid_reg  <= tx_valid_next;
            tx_byte_reg   <= tx_byte_next;
            irq_reg       <= irq_next;
        end
    end

    assign done      = done_reg;
    assign read_data = read_data_reg;
    assign tx_valid  = tx_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign interrupt = irq_reg;

endmodule

`default_nettype wire
